[rtl/core/periodic_scan_group_scheduler_unit_defines.svh]
// assertion macros for the periodic scan group scheduler
// used by modules that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef PERIODIC_SCAN_GROUP_SCHEDULER_UNIT_DEFINES_SVH
`define PERIODIC_SCAN_GROUP_SCHEDULER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PSG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("psg assertion failed");
`define PSG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("psg forbidden condition seen");
`else
`define PSG_ASSERT(lbl, prop)
`define PSG_ASSERT_NEVER(lbl, cond)
`endif
`endif

[rtl/core/psg_pkg.sv]
// shared types and constants of the periodic scan group scheduler
// no dependencies
package psg_pkg;

  localparam int NUM_GROUPS   = 8;
  localparam int NUM_CHANNELS = 64;

  localparam int CH_W     = 6;
  localparam int PER_W    = 16;
  localparam int TIME_W   = 32;
  localparam int NEXT_W   = 7;
  localparam int TAG_W    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int GCNT_W   = $clog2(NUM_GROUPS + 1);
  localparam int CMDQ_DEPTH = 2;

  localparam logic [NEXT_W-1:0] LIST_END = NEXT_W'(NUM_CHANNELS);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_SET_LINK = 2'd2,
    OP_SCAN     = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CH_W-1:0]   ch;
    logic              ch_ok;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] t;
    logic              link;
  } cmd_t;

  typedef struct packed {
    logic              strobe;
    logic [CH_W-1:0]   read_channel;
    logic              read_valid;
    logic              last_item;
    logic              status;
    logic [TIME_W-1:0] earliest_due;
    logic              earliest_valid;
  } res_t;

endpackage

[rtl/core/psg_front.sv]
// front end: takes commands and classifies them for the queue
// depends on psg_pkg
module psg_front import psg_pkg::*; (
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation_i,
  input  logic [CH_W-1:0]   channel_id_i,
  input  logic [PER_W-1:0]  period_seconds_i,
  input  logic [TIME_W-1:0] time_seconds_i,
  input  logic              link_up_i,
  input  logic              q_full_i,
  output logic              push_o,
  output cmd_t              cmd_o
);

  assign busy   = q_full_i;
  assign push_o = start && !q_full_i;

  always_comb begin
    cmd_o.op     = op_e'(operation_i);
    cmd_o.ch     = channel_id_i;
    // channels past the table are ignored by the back end
    cmd_o.ch_ok  = ({1'b0, channel_id_i} < NEXT_W'(NUM_CHANNELS));
    // zero period behaves as one second
    cmd_o.period = (period_seconds_i == '0) ? PER_W'(1) : period_seconds_i;
    cmd_o.t      = time_seconds_i;
    cmd_o.link   = link_up_i;
  end

endmodule

[rtl/core/psg_cmd_fifo.sv]
// short command queue between front and back end
// depends on psg_pkg
module psg_cmd_fifo import psg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             ent_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/psg_div.sv]
// round-up unit: base + dividend rounded up to a multiple of divisor, saturated
// bit-serial remainder, one dividend bit per cycle; depends on psg_pkg
module psg_div import psg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] dividend_i,
  input  logic [PER_W-1:0]  divisor_i,
  input  logic [TIME_W-1:0] base_i,
  output logic              done_o,
  output logic [TIME_W-1:0] result_o
);

  localparam int CNT_W = $clog2(TIME_W);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } dst_e;

  dst_e              st_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] sh_q, d_q, base_q;
  logic [PER_W-1:0]  div_q;
  logic [PER_W:0]    rem_q;
  logic [PER_W:0]    rem_sh, rem_d;
  logic [TIME_W+1:0] sum;

  always_comb begin
    rem_sh = {rem_q[PER_W-1:0], sh_q[TIME_W-1]};
    rem_d  = (rem_sh >= {1'b0, div_q}) ? rem_sh - {1'b0, div_q} : rem_sh;
    sum    = {2'b00, base_q} + {2'b00, d_q} +
             ((rem_q != '0) ? (TIME_W+2)'(div_q - rem_q[PER_W-1:0]) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= D_IDLE;
      cnt_q    <= '0;
      sh_q     <= '0;
      d_q      <= '0;
      base_q   <= '0;
      div_q    <= '0;
      rem_q    <= '0;
      done_o   <= 1'b0;
      result_o <= '0;
    end else begin
      done_o <= (st_q == D_FIN);
      unique case (st_q)
        D_IDLE: begin
          if (start_i) begin
            sh_q   <= dividend_i;
            d_q    <= dividend_i;
            base_q <= base_i;
            div_q  <= divisor_i;
            rem_q  <= '0;
            cnt_q  <= '0;
            st_q   <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= rem_d;
          sh_q  <= {sh_q[TIME_W-2:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(TIME_W - 1)) begin
            st_q <= D_FIN;
          end
        end
        D_FIN: begin
          result_o <= (sum > {2'b00, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
          st_q     <= D_IDLE;
        end
        default: st_q <= D_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/psg_back.sv]
// back end: group table, member lists, scan walk and result drain
// depends on psg_pkg, psg_div and the assertion macro header
`include "periodic_scan_group_scheduler_unit_defines.svh"
module psg_back import psg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_empty_i,
  input  cmd_t q_cmd_i,
  output logic pop_o,
  output res_t res_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_TO_MG,
    S_TO_GRP,
    S_TO_HEAD,
    S_TO_RD,
    S_TO_CHK,
    S_TO_CLR,
    S_TO_DROP,
    S_AD_SRCH,
    S_AD_WAIT,
    S_AD_LINK1,
    S_AD_LINK2,
    S_SC_SLOT,
    S_SC_CHK,
    S_SC_WAIT,
    S_SC_HEAD,
    S_SC_RD,
    S_SC_NX,
    S_SC_EARLY,
    S_DR_START,
    S_DR_RD,
    S_DR_EM,
    S_RESULT
  } st_e;

  st_e               state_q;
  cmd_t              cmd_q;
  logic [TAG_W-1:0]  tag_q;
  logic [GCNT_W-1:0] slot_q, count_q;
  logic [NEXT_W-1:0] cur_q, prev_q, steps_q, nbuf_q, k_q;
  logic              status_q;
  logic              due_known_q;
  logic [TIME_W-1:0] due_time_q;
  logic [TAG_W-1:0]  order_q [NUM_GROUPS];
  logic [NUM_GROUPS-1:0]   tag_used_q;
  logic [NUM_CHANNELS-1:0] link_q, mg_vld_q;
  res_t              res_q;

  // per-group attributes, indexed by a stable tag
  logic [PER_W-1:0]  grp_per_q  [NUM_GROUPS];
  logic [TIME_W-1:0] grp_due_q  [NUM_GROUPS];
  logic [NEXT_W-1:0] grp_head_q [NUM_GROUPS];
  logic [NEXT_W-1:0] grp_tail_q [NUM_GROUPS];

  // memories
  logic [NEXT_W-1:0] mn_mem  [NUM_CHANNELS];
  logic [GCNT_W-1:0] mg_mem  [NUM_CHANNELS];
  logic [CH_W-1:0]   buf_mem [NUM_CHANNELS];
  logic [NEXT_W-1:0] nx_rd_q;
  logic [GCNT_W-1:0] mg_rd_q;
  logic [CH_W-1:0]   buf_rd_q;

  logic [TAG_W-1:0]  rd_tag, free_tag;
  logic [PER_W-1:0]  per_r;
  logic [TIME_W-1:0] due_r;
  logic [NEXT_W-1:0] head_r, tail_r;
  logic [GCNT_W-1:0] drop_pos;
  logic              found_ch, walk_end, head_empty, tail_hit, slot_live;
  logic              due_upd, mg_hit;
  logic              res_fire;

  logic              mn_we;
  logic [CH_W-1:0]   mn_waddr;
  logic [NEXT_W-1:0] mn_wdata;
  logic              per_we, due_we, head_we, tail_we;
  logic [NEXT_W-1:0] head_wdata, tail_wdata;
  logic              buf_we;

  logic              div_start, div_done;
  logic [TIME_W-1:0] div_dvd, div_base, div_res;
  logic [PER_W-1:0]  div_per;

  assign rd_tag = (state_q == S_AD_SRCH) ? order_q[slot_q[TAG_W-1:0]] : tag_q;
  assign per_r  = grp_per_q[rd_tag];
  assign due_r  = grp_due_q[rd_tag];
  assign head_r = grp_head_q[rd_tag];
  assign tail_r = grp_tail_q[rd_tag];

  // a new group rounds with its own period, a scan with the group's
  assign div_per = (state_q == S_AD_SRCH) ? cmd_q.period : per_r;

  assign found_ch   = (cur_q[CH_W-1:0] == cmd_q.ch);
  assign walk_end   = (cur_q >= LIST_END) || (steps_q >= NEXT_W'(NUM_CHANNELS));
  assign head_empty = (head_r >= LIST_END);
  assign tail_hit   = (tail_r == {1'b0, cmd_q.ch});
  assign slot_live  = (slot_q < count_q);
  assign due_upd    = !due_known_q || (due_time_q > due_r);
  assign mg_hit     = mg_vld_q[cmd_q.ch] && (mg_rd_q != '0);
  assign pop_o      = (state_q == S_IDLE) && !q_empty_i;
  assign res_fire   = ((state_q == S_DR_START) && (nbuf_q == '0)) ||
                      (state_q == S_DR_EM) || (state_q == S_RESULT);

  always_comb begin
    free_tag = '0;
    for (int k = NUM_GROUPS - 1; k >= 0; k--) begin
      if (!tag_used_q[k]) begin
        free_tag = TAG_W'(k);
      end
    end
  end

  always_comb begin
    drop_pos = '0;
    for (int k = NUM_GROUPS - 1; k >= 0; k--) begin
      if ((order_q[k] == tag_q) && (GCNT_W'(k) < count_q)) begin
        drop_pos = GCNT_W'(k);
      end
    end
  end

  // write strobes for memories and the group table
  always_comb begin
    mn_we      = 1'b0;
    mn_waddr   = cmd_q.ch;
    mn_wdata   = LIST_END;
    per_we     = 1'b0;
    due_we     = 1'b0;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    head_wdata = LIST_END;
    tail_wdata = LIST_END;
    buf_we     = 1'b0;
    div_start  = 1'b0;
    div_dvd    = cmd_q.t;
    div_base   = '0;
    unique case (state_q)
      S_TO_CHK: begin
        if (found_ch) begin
          if (prev_q == LIST_END) begin
            head_we    = 1'b1;
            head_wdata = nx_rd_q;
          end else begin
            mn_we    = 1'b1;
            mn_waddr = prev_q[CH_W-1:0];
            mn_wdata = nx_rd_q;
          end
          if (tail_hit) begin
            tail_we    = 1'b1;
            tail_wdata = prev_q;
          end
        end
      end
      S_AD_SRCH: begin
        if (!(slot_live && per_r == cmd_q.period) && !slot_live &&
            (count_q < GCNT_W'(NUM_GROUPS))) begin
          div_start = 1'b1;
        end
      end
      S_AD_WAIT: begin
        if (div_done) begin
          per_we  = 1'b1;
          due_we  = 1'b1;
          head_we = 1'b1;
          tail_we = 1'b1;
        end
      end
      S_AD_LINK1: begin
        mn_we = 1'b1;
      end
      S_AD_LINK2: begin
        if (head_empty) begin
          head_we    = 1'b1;
          head_wdata = {1'b0, cmd_q.ch};
        end else if (tail_r < LIST_END) begin
          mn_we    = 1'b1;
          mn_waddr = tail_r[CH_W-1:0];
          mn_wdata = {1'b0, cmd_q.ch};
        end
        tail_we    = 1'b1;
        tail_wdata = {1'b0, cmd_q.ch};
      end
      S_SC_CHK: begin
        div_dvd  = cmd_q.t - due_r;
        div_base = due_r;
        if (cmd_q.t > due_r) begin
          div_start = 1'b1;
        end
      end
      S_SC_WAIT: begin
        due_we = div_done;
      end
      S_SC_NX: begin
        buf_we = link_q[cur_q[CH_W-1:0]] && (nbuf_q < NEXT_W'(NUM_CHANNELS));
      end
      default: begin
      end
    endcase
  end

  psg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_per),
    .base_i     (div_base),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  always_ff @(posedge clk_i) begin
    if (per_we) begin
      grp_per_q[tag_q] <= cmd_q.period;
    end
    if (due_we) begin
      grp_due_q[tag_q] <= div_res;
    end
    if (head_we) begin
      grp_head_q[tag_q] <= head_wdata;
    end
    if (tail_we) begin
      grp_tail_q[tag_q] <= tail_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mn_we) begin
      mn_mem[mn_waddr] <= mn_wdata;
    end
    nx_rd_q <= mn_mem[cur_q[CH_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_AD_LINK1) begin
      mg_mem[cmd_q.ch] <= GCNT_W'(tag_q) + 1'b1;
    end
    mg_rd_q <= mg_mem[cmd_q.ch];
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[nbuf_q[CH_W-1:0]] <= cur_q[CH_W-1:0];
    end
    buf_rd_q <= buf_mem[k_q[CH_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      tag_q       <= '0;
      slot_q      <= '0;
      count_q     <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      steps_q     <= '0;
      nbuf_q      <= '0;
      k_q         <= '0;
      status_q    <= 1'b0;
      due_known_q <= 1'b0;
      due_time_q  <= '0;
      tag_used_q  <= '0;
      link_q      <= '0;
      mg_vld_q    <= '0;
      res_q       <= '0;
      for (int k = 0; k < NUM_GROUPS; k++) begin
        order_q[k] <= '0;
      end
    end else begin
      res_q.strobe <= res_fire;
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            cmd_q    <= q_cmd_i;
            status_q <= 1'b0;
            priority if (q_cmd_i.op == OP_SCAN) begin
              due_known_q <= 1'b0;
              due_time_q  <= '0;
              slot_q      <= '0;
              nbuf_q      <= '0;
              state_q     <= S_SC_SLOT;
            end else if (!q_cmd_i.ch_ok) begin
              state_q <= S_RESULT;
            end else if (q_cmd_i.op == OP_SET_LINK) begin
              link_q[q_cmd_i.ch] <= q_cmd_i.link;
              state_q            <= S_RESULT;
            end else begin
              state_q <= S_TO_MG;
            end
          end
        end
        S_TO_MG: state_q <= S_TO_GRP;
        S_TO_GRP: begin
          prev_q  <= LIST_END;
          steps_q <= '0;
          slot_q  <= '0;
          if (mg_hit) begin
            tag_q   <= TAG_W'(mg_rd_q - 1'b1);
            state_q <= S_TO_HEAD;
          end else begin
            state_q <= (cmd_q.op == OP_ADD) ? S_AD_SRCH : S_RESULT;
          end
        end
        S_TO_HEAD: begin
          cur_q   <= head_r;
          state_q <= S_TO_RD;
        end
        S_TO_RD: state_q <= walk_end ? S_TO_CLR : S_TO_CHK;
        S_TO_CHK: begin
          if (found_ch) begin
            state_q <= S_TO_CLR;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= nx_rd_q;
            steps_q <= steps_q + 1'b1;
            state_q <= S_TO_RD;
          end
        end
        S_TO_CLR: begin
          mg_vld_q[cmd_q.ch] <= 1'b0;
          state_q            <= S_TO_DROP;
        end
        S_TO_DROP: begin
          // an emptied group leaves the creation order, later ones move down
          if (head_empty) begin
            tag_used_q[tag_q] <= 1'b0;
            for (int k = 0; k < NUM_GROUPS - 1; k++) begin
              if (GCNT_W'(k) >= drop_pos) begin
                order_q[k] <= order_q[k+1];
              end
            end
            count_q <= count_q - 1'b1;
          end
          state_q <= (cmd_q.op == OP_ADD) ? S_AD_SRCH : S_RESULT;
        end
        S_AD_SRCH: begin
          if (slot_live) begin
            if (per_r == cmd_q.period) begin
              tag_q   <= rd_tag;
              state_q <= S_AD_LINK1;
            end else begin
              slot_q <= slot_q + 1'b1;
            end
          end else if (count_q >= GCNT_W'(NUM_GROUPS)) begin
            status_q <= 1'b1;
            state_q  <= S_RESULT;
          end else begin
            tag_q   <= free_tag;
            state_q <= S_AD_WAIT;
          end
        end
        S_AD_WAIT: begin
          if (div_done) begin
            tag_used_q[tag_q]                 <= 1'b1;
            order_q[count_q[TAG_W-1:0]]       <= tag_q;
            count_q                           <= count_q + 1'b1;
            state_q                           <= S_AD_LINK1;
          end
        end
        S_AD_LINK1: begin
          mg_vld_q[cmd_q.ch] <= 1'b1;
          state_q            <= S_AD_LINK2;
        end
        S_AD_LINK2: begin
          if (due_upd) begin
            due_time_q  <= due_r;
            due_known_q <= 1'b1;
          end
          state_q <= S_RESULT;
        end
        S_SC_SLOT: begin
          if (slot_live) begin
            tag_q   <= order_q[slot_q[TAG_W-1:0]];
            state_q <= S_SC_CHK;
          end else begin
            state_q <= S_DR_START;
          end
        end
        S_SC_CHK: begin
          priority if (cmd_q.t > due_r) begin
            state_q <= S_SC_WAIT;
          end else if (cmd_q.t == due_r) begin
            state_q <= S_SC_HEAD;
          end else begin
            state_q <= S_SC_EARLY;
          end
        end
        S_SC_WAIT: begin
          if (div_done) begin
            state_q <= S_SC_HEAD;
          end
        end
        S_SC_HEAD: begin
          cur_q   <= head_r;
          steps_q <= '0;
          state_q <= S_SC_RD;
        end
        S_SC_RD: state_q <= walk_end ? S_SC_EARLY : S_SC_NX;
        S_SC_NX: begin
          if (buf_we) begin
            nbuf_q <= nbuf_q + 1'b1;
          end
          cur_q   <= nx_rd_q;
          steps_q <= steps_q + 1'b1;
          state_q <= S_SC_RD;
        end
        S_SC_EARLY: begin
          if (due_upd) begin
            due_time_q  <= due_r;
            due_known_q <= 1'b1;
          end
          slot_q  <= slot_q + 1'b1;
          state_q <= S_SC_SLOT;
        end
        S_DR_START: begin
          k_q <= '0;
          if (nbuf_q == '0) begin
            res_q.read_channel   <= '0;
            res_q.read_valid     <= 1'b0;
            res_q.last_item      <= 1'b1;
            res_q.status         <= 1'b0;
            res_q.earliest_due   <= due_known_q ? due_time_q : '0;
            res_q.earliest_valid <= due_known_q;
            state_q              <= S_IDLE;
          end else begin
            state_q <= S_DR_RD;
          end
        end
        S_DR_RD: state_q <= S_DR_EM;
        S_DR_EM: begin
          res_q.read_channel   <= buf_rd_q;
          res_q.read_valid     <= 1'b1;
          res_q.last_item      <= (k_q + 1'b1 == nbuf_q);
          res_q.status         <= 1'b0;
          res_q.earliest_due   <= due_known_q ? due_time_q : '0;
          res_q.earliest_valid <= due_known_q;
          k_q                  <= k_q + 1'b1;
          state_q              <= (k_q + 1'b1 == nbuf_q) ? S_IDLE : S_DR_RD;
        end
        S_RESULT: begin
          res_q.read_channel   <= '0;
          res_q.read_valid     <= 1'b0;
          res_q.last_item      <= 1'b1;
          res_q.status         <= status_q;
          res_q.earliest_due   <= due_known_q ? due_time_q : '0;
          res_q.earliest_valid <= due_known_q;
          state_q              <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o = res_q;

  `PSG_ASSERT(a_count_max, count_q <= GCNT_W'(NUM_GROUPS))
  `PSG_ASSERT(a_tags_match_count, $countones(tag_used_q) == int'(count_q))
  `PSG_ASSERT(a_plain_is_last, res_q.strobe && !res_q.read_valid |-> res_q.last_item)
  `PSG_ASSERT(a_div_awaited, div_done |-> (state_q == S_AD_WAIT || state_q == S_SC_WAIT))
  `PSG_ASSERT(a_buf_bound, nbuf_q <= NEXT_W'(NUM_CHANNELS))

endmodule

[rtl/core/periodic_scan_group_scheduler_unit.sv]
// top level of the periodic scan group scheduler
// depends on psg_pkg, psg_front, psg_cmd_fifo, psg_back (and psg_div below it)
//
//  channel   direction  handshake             payload
//  command   in         start / busy          operation, channel_id, period_seconds,
//                                             time_seconds, link_up
//  result    out        result_valid_o strobe read_channel, read_valid, last_item,
//                                             status, earliest_due, earliest_valid
//
// add/remove walk the member list to unlink the channel, passing each member ahead of it,
// an add also compares the groups one by one, and opening a group waits on the round-up
// a scan checks each group in turn, advances an overdue group through the round-up,
// walks the members of each due group, then drains the buffered reads word by word
// the serial round-up unit (one time bit per cycle) and the list walks set how long each command runs
// reset clears groups, membership and link flags at once; no sweep is needed
// busy only rises when the two-entry command queue is full
// result words cannot be held off by the receiver
module periodic_scan_group_scheduler_unit import psg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation_i,
  input  logic [CH_W-1:0]   channel_id_i,
  input  logic [PER_W-1:0]  period_seconds_i,
  input  logic [TIME_W-1:0] time_seconds_i,
  input  logic              link_up_i,
  output logic              result_valid_o,
  output logic [CH_W-1:0]   read_channel_o,
  output logic              read_valid_o,
  output logic              last_item_o,
  output logic              status_o,
  output logic [TIME_W-1:0] earliest_due_o,
  output logic              earliest_valid_o
);

  // classified command going into the queue
  cmd_t front_cmd;
  logic front_push;
  // queue head seen by the back end
  cmd_t q_cmd;
  logic q_full, q_empty, q_pop;
  // registered result word
  res_t res;

  psg_front u_front (
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .channel_id_i     (channel_id_i),
    .period_seconds_i (period_seconds_i),
    .time_seconds_i   (time_seconds_i),
    .link_up_i        (link_up_i),
    .q_full_i         (q_full),
    .push_o           (front_push),
    .cmd_o            (front_cmd)
  );

  psg_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back end runs one command at a time: link flag update, unlink, group search or open,
  // link, or the scan walk that buffers reads and then drains them
  psg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_cmd),
    .pop_o     (q_pop),
    .res_o     (res)
  );

  assign result_valid_o   = res.strobe;
  assign read_channel_o   = res.read_channel;
  assign read_valid_o     = res.read_valid;
  assign last_item_o      = res.last_item;
  assign status_o         = res.status;
  assign earliest_due_o   = res.earliest_due;
  assign earliest_valid_o = res.earliest_valid;

endmodule

[test/periodic_scan_group_scheduler_unit_test.sv]
// self-checking testbench of the periodic scan group scheduler unit
// depends on psg_pkg and periodic_scan_group_scheduler_unit; compares every result word
// with a behavioral predictor of the period groups
module periodic_scan_group_scheduler_unit_test;
  import psg_pkg::*;

  // one command word as driven on the input ports
  typedef struct {
    op_e         op;
    logic [5:0]  ch;
    logic [15:0] period;
    logic [31:0] t;
    logic        link;
  } cmd_word_t;

  // one result word as predicted
  typedef struct {
    logic [5:0]  ch;
    logic        rd_ok;
    logic        last;
    logic        status;
    logic [31:0] due;
    logic        due_ok;
  } res_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = '0;
  logic [5:0]  channel_id_i = '0;
  logic [15:0] period_seconds_i = '0;
  logic [31:0] time_seconds_i = '0;
  logic        link_up_i = 1'b0;
  logic        result_valid_o;
  logic [5:0]  read_channel_o;
  logic        read_valid_o;
  logic        last_item_o;
  logic        status_o;
  logic [31:0] earliest_due_o;
  logic        earliest_valid_o;

  cmd_word_t pending_cmds[$];
  res_word_t expected_words[$];
  int        fail_count = 0;
  int        sent_count = 0;

  always #1 clk_i = ~clk_i;

  periodic_scan_group_scheduler_unit uut (
    .clk_i, .rst_ni, .start, .busy,
    .operation_i, .channel_id_i, .period_seconds_i, .time_seconds_i, .link_up_i,
    .result_valid_o, .read_channel_o, .read_valid_o, .last_item_o, .status_o,
    .earliest_due_o, .earliest_valid_o
  );

  // ------------------------------------------------------------------
  // predictor state: groups packed in slots 0..count-1 in creation order
  // ------------------------------------------------------------------
  bit          grp_used[NUM_GROUPS];
  bit [15:0]   grp_period[NUM_GROUPS];
  bit [31:0]   grp_due[NUM_GROUPS];
  bit [6:0]    grp_head[NUM_GROUPS];
  bit [6:0]    grp_tail[NUM_GROUPS];
  bit [6:0]    chan_next[NUM_CHANNELS];
  int          chan_group[NUM_CHANNELS];  // 0 none, else slot plus one
  bit          chan_link[NUM_CHANNELS];
  bit [31:0]   soonest_due;
  bit          soonest_known;

  function automatic int groups_in_use();
    int n;
    n = 0;
    while (n < NUM_GROUPS && grp_used[n]) n++;
    return n;
  endfunction

  // drop slot s and slide the later groups down one place
  function automatic void retire_group(int s);
    for (int i = s; i + 1 < NUM_GROUPS; i++) begin
      grp_used[i]   = grp_used[i+1];
      grp_period[i] = grp_period[i+1];
      grp_due[i]    = grp_due[i+1];
      grp_head[i]   = grp_head[i+1];
      grp_tail[i]   = grp_tail[i+1];
    end
    grp_used[NUM_GROUPS-1] = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++)
      if (chan_group[i] > s + 1) chan_group[i]--;
  endfunction

  function automatic void unlink_channel(int ch);
    int s, cur, prev, steps;
    if (chan_group[ch] == 0) return;
    s = chan_group[ch] - 1;
    cur = int'(grp_head[s]);
    prev = NUM_CHANNELS;
    steps = 0;
    while (cur < NUM_CHANNELS && steps < NUM_CHANNELS) begin
      if (cur == ch) begin
        if (prev == NUM_CHANNELS) grp_head[s] = chan_next[cur];
        else chan_next[prev] = chan_next[cur];
        if (grp_tail[s] == ch) grp_tail[s] = 7'(prev);
        break;
      end
      prev = cur;
      cur = int'(chan_next[cur]);
      steps++;
    end
    chan_group[ch] = 0;
    if (grp_head[s] >= NUM_CHANNELS) retire_group(s);
  endfunction

  function automatic bit [31:0] clamp_time(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic void add_expected(int ch, bit rd_ok, bit last, bit status);
    res_word_t w;
    w.ch = 6'(ch);
    w.rd_ok = rd_ok;
    w.last = last;
    w.status = status;
    w.due = soonest_known ? soonest_due : 32'd0;
    w.due_ok = soonest_known;
    expected_words.insert(expected_words.size(), w);
  endfunction

  // update the group model for one accepted command, queue its result words
  function automatic void predict_schedule(cmd_word_t c);
    int reads[$];
    int count, s, cur, steps;
    longint unsigned p, m;
    bit status;
    status = 1'b0;
    if (c.op == OP_SCAN) begin
      count = groups_in_use();
      soonest_known = 1'b0;
      soonest_due = '0;
      for (int i = 0; i < count; i++) begin
        if (c.t >= grp_due[i]) begin
          p = (grp_period[i] != 0) ? 64'(grp_period[i]) : 64'd1;
          if (c.t > grp_due[i]) begin
            m = (64'(c.t - grp_due[i]) + p - 1) / p;
            grp_due[i] = clamp_time(64'(grp_due[i]) + m * p);
          end
          cur = int'(grp_head[i]);
          steps = 0;
          while (cur < NUM_CHANNELS && steps < NUM_CHANNELS) begin
            if (chan_link[cur] && reads.size() < 64) reads.insert(reads.size(), cur);
            cur = int'(chan_next[cur]);
            steps++;
          end
        end
        if (!soonest_known || soonest_due > grp_due[i]) begin
          soonest_due = grp_due[i];
          soonest_known = 1'b1;
        end
      end
      if (reads.size() == 0) add_expected(0, 1'b0, 1'b1, 1'b0);
      foreach (reads[k]) add_expected(reads[k], 1'b1, k == reads.size() - 1, 1'b0);
      return;
    end
    if (c.op == OP_SET_LINK) chan_link[c.ch] = c.link;
    else if (c.op == OP_REMOVE) unlink_channel(int'(c.ch));
    else begin
      p = (c.period != 0) ? 64'(c.period) : 64'd1;
      unlink_channel(int'(c.ch));
      count = groups_in_use();
      s = NUM_GROUPS;
      for (int i = 0; i < count; i++)
        if (grp_period[i] == p) begin
          s = i;
          break;
        end
      if (s == NUM_GROUPS) begin
        if (count >= NUM_GROUPS) status = 1'b1;
        else begin
          // round the current time up to a multiple of the period
          m = (64'(c.t) + p - 1) / p;
          s = count;
          grp_used[s] = 1'b1;
          grp_period[s] = 16'(p);
          grp_due[s] = clamp_time(m * p);
          grp_head[s] = 7'(NUM_CHANNELS);
          grp_tail[s] = 7'(NUM_CHANNELS);
        end
      end
      if (!status) begin
        chan_next[c.ch] = 7'(NUM_CHANNELS);
        if (grp_head[s] >= NUM_CHANNELS) grp_head[s] = {1'b0, c.ch};
        else if (grp_tail[s] < NUM_CHANNELS) chan_next[grp_tail[s]] = {1'b0, c.ch};
        grp_tail[s] = {1'b0, c.ch};
        chan_group[c.ch] = s + 1;
        if (!soonest_known || soonest_due > grp_due[s]) begin
          soonest_due = grp_due[s];
          soonest_known = 1'b1;
        end
      end
    end
    add_expected(0, 1'b0, 1'b1, status);
  endfunction

  // ------------------------------------------------------------------
  // driver: a word is taken at an edge with start high and busy low
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    cmd_word_t c;
    bit taken, quiet;
    taken = start && !busy;
    if (rst_ni) begin
      if (taken) begin
        c = pending_cmds[0];
        pending_cmds.delete(0);
        predict_schedule(c);
        sent_count++;
      end
      if (!start || taken) begin
        // idle about a third of the time, except for one long busy stretch
        quiet = (sent_count < 120 || sent_count > 200) && ($urandom_range(0, 99) < 32);
        if (pending_cmds.size() > 0 && !quiet) begin
          c = pending_cmds[0];
          operation_i      <= c.op;
          channel_id_i     <= c.ch;
          period_seconds_i <= c.period;
          time_seconds_i   <= c.t;
          link_up_i        <= c.link;
          start            <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: every strobed word is checked against the oldest prediction
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_word_t w;
    if (rst_ni && result_valid_o) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word ch=%0d rv=%0d", $time, read_channel_o, read_valid_o);
        fail_count++;
      end else begin
        w = expected_words[0];
        expected_words.delete(0);
        if (read_channel_o !== w.ch) begin
          $display("%0t: read_channel exp %0d got %0d", $time, w.ch, read_channel_o);
          fail_count++;
        end
        if (read_valid_o !== w.rd_ok) begin
          $display("%0t: read_valid exp %0d got %0d", $time, w.rd_ok, read_valid_o);
          fail_count++;
        end
        if (last_item_o !== w.last) begin
          $display("%0t: last_item exp %0d got %0d", $time, w.last, last_item_o);
          fail_count++;
        end
        if (status_o !== w.status) begin
          $display("%0t: status exp %0d got %0d", $time, w.status, status_o);
          fail_count++;
        end
        if (earliest_due_o !== w.due) begin
          $display("%0t: earliest_due exp %0d got %0d", $time, w.due, earliest_due_o);
          fail_count++;
        end
        if (earliest_valid_o !== w.due_ok) begin
          $display("%0t: earliest_valid exp %0d got %0d", $time, w.due_ok,
                   earliest_valid_o);
          fail_count++;
        end
      end
    end
  end

  function automatic void queue_cmd(op_e op, int ch, int period, bit [31:0] t, bit link);
    cmd_word_t c;
    c.op = op;
    c.ch = 6'(ch);
    c.period = 16'(period);
    c.t = t;
    c.link = link;
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // a small pool of periods so channels share groups and slots run out
  function automatic int pick_period();
    int pool[10] = '{1, 2, 3, 5, 7, 10, 13, 60, 0, 300};
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535));
    return pool[$urandom_range(0, 9)];
  endfunction

  initial begin
    bit [31:0] now;
    int r;
    // ---------------- directed part ----------------
    queue_cmd(OP_SCAN, 0, 0, 0, 1'b0);                    // scan with no groups
    queue_cmd(OP_ADD, 0, 0, 32'd7, 1'b0);                 // zero period acts as one
    queue_cmd(OP_ADD, 63, 65535, 32'hFFFF_FFFF, 1'b0);    // due time lands on the largest time value
    queue_cmd(OP_SET_LINK, 0, 0, 0, 1'b1);
    queue_cmd(OP_SET_LINK, 63, 0, 0, 1'b1);
    queue_cmd(OP_ADD, 5, 1, 32'd3, 1'b0);                 // joins the period-one group
    queue_cmd(OP_SET_LINK, 5, 0, 0, 1'b1);
    queue_cmd(OP_SCAN, 0, 0, 32'd20, 1'b0);
    queue_cmd(OP_SCAN, 0, 0, 32'hFFFF_FFFF, 1'b0);        // advance reaches the largest time value
    queue_cmd(OP_ADD, 0, 65535, 32'd100, 1'b0);           // moves to another group
    queue_cmd(OP_REMOVE, 5, 0, 0, 1'b0);                  // empties a group, stale earliest
    for (int i = 0; i < 8; i++)                           // run out of group slots
      queue_cmd(OP_ADD, 10 + i, 2 + i, 32'd50, 1'b0);
    queue_cmd(OP_SCAN, 0, 0, 32'd60, 1'b0);
    queue_cmd(OP_REMOVE, 40, 0, 0, 1'b0);                 // channel in no group
    for (int i = 0; i < 64; i += 16) queue_cmd(OP_REMOVE, i + 10, 0, 0, 1'b0);
    queue_cmd(OP_SCAN, 0, 0, 32'd70, 1'b0);
    // ---------------- random part ----------------
    now = 32'd1000;
    for (int n = 0; n < 300; n++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 29) == 0) now = $urandom;  // jump anywhere in time
      if (r < 35)
        queue_cmd(OP_ADD, $urandom_range(0, 63), pick_period(), now, 1'b0);
      else if (r < 45)
        queue_cmd(OP_REMOVE, $urandom_range(0, 63), $urandom, $urandom, 1'($urandom));
      else if (r < 70)
        queue_cmd(OP_SET_LINK, $urandom_range(0, 63), $urandom,
                  $urandom, $urandom_range(0, 3) != 0);
      else begin
        now = now + $urandom_range(0, 40);
        queue_cmd(OP_SCAN, $urandom, $urandom, now, 1'($urandom));
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0 && expected_words.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
